FILE: hdl/ssa_pkg.sv
package ssa_pkg;

    // Default number of ids the allocator manages.
    localparam int ID_CAPACITY_DEF = 64;

    // Fixed field widths at the ports.
    localparam int ID_FIELD_W    = 6;
    localparam int COUNT_FIELD_W = 7;

    // Request codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NOT_LIVE = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    init_write;  // write identity entry at the sweep index
        logic    capture;     // latch the request and launch the table reads
        logic    swap_a;      // first write pair of a free
        logic    swap_b;      // second write pair of a free
        logic    count_inc;
        logic    count_dec;
        logic    emit;        // load the result registers
        logic    give_id;     // result carries the looked up id
        status_t status;
    } ssa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;  // sweep index is on the last entry
        logic req_free;   // captured request is a free
        logic full;       // every id is live
        logic live_ok;    // captured free names a live id
    } ssa_stat_t;

endpackage

FILE: hdl/sparse_set_id_allocator_top.sv
// Order of steps: start is taken and the table reads are launched; an allocate, or a refused free,
// emits its result from the lookup state, while a granted free goes on through the two swap states,
// set by the single write port of each table, and emits from the second. done is registered after
// the emitting state. The next request may start when busy is low again.
// After reset the block sweeps every entry of both tables to the identity mapping, with busy high.
// The result strobe done is high for one cycle per request; the receiver cannot stall it.
module sparse_set_id_allocator_top
    import ssa_pkg::*;
#(
    parameter int ID_CAPACITY = ID_CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic [ID_FIELD_W-1:0]    free_id,
    output logic                     done,
    output logic [1:0]               status,
    output logic [ID_FIELD_W-1:0]    alloc_id,
    output logic [COUNT_FIELD_W-1:0] live_count
);

    ssa_cmd_t  cmd;
    ssa_stat_t stat;

    // Request sequencing.
    ssa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Tables, live count and result registers.
    ssa_datapath #(
        .ID_CAPACITY (ID_CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .free_id    (free_id),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .status     (status),
        .alloc_id   (alloc_id),
        .live_count (live_count)
    );

endmodule

FILE: hdl/ssa_ctrl.sv
module ssa_ctrl
    import ssa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  ssa_stat_t stat,
    output ssa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_SWAP_A,
        ST_SWAP_B
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Next state and the command for the current cycle.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STATUS_OK;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_write = 1'b1;
                if (stat.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!stat.req_free)
                begin
                    // Allocate finishes here, granted or refused.
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                    if (stat.full)
                    begin
                        cmd.status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.give_id   = 1'b1;
                        cmd.count_inc = 1'b1;
                    end
                end
                else if (!stat.live_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = STATUS_NOT_LIVE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SWAP_A;
                end
            end
            ST_SWAP_A:
            begin
                cmd.swap_a = 1'b1;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                cmd.swap_b    = 1'b1;
                cmd.count_dec = 1'b1;
                cmd.emit      = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and the registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

FILE: hdl/ssa_datapath.sv
module ssa_datapath
    import ssa_pkg::*;
#(
    parameter int ID_CAPACITY = ID_CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_type,
    input  logic [ID_FIELD_W-1:0]    free_id,
    input  ssa_cmd_t                 cmd,
    output ssa_stat_t                stat,
    output logic                     done,
    output logic [1:0]               status,
    output logic [ID_FIELD_W-1:0]    alloc_id,
    output logic [COUNT_FIELD_W-1:0] live_count
);

    localparam int IW = (ID_CAPACITY > 1) ? $clog2(ID_CAPACITY) : 1;
    localparam int CW = $clog2(ID_CAPACITY + 1);

    // Dense table: slot to id. Sparse table: id to slot.
    logic [IW-1:0] dense_mem  [ID_CAPACITY];
    logic [IW-1:0] sparse_mem [ID_CAPACITY];

    logic [IW-1:0]            init_idx_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     req_free_reg;
    logic                     id_ok_reg;
    logic [IW-1:0]            id_reg;
    logic [IW-1:0]            dense_rd_reg;
    logic [IW-1:0]            sparse_rd_reg;
    logic                     done_reg;
    status_t                  status_reg;
    logic [ID_FIELD_W-1:0]    alloc_id_reg;
    logic [COUNT_FIELD_W-1:0] live_count_reg;

    logic [IW-1:0] last_slot;
    logic [IW-1:0] dense_raddr;
    logic [IW-1:0] sparse_raddr;
    logic          dense_we;
    logic [IW-1:0] dense_waddr;
    logic [IW-1:0] dense_wdata;
    logic          sparse_we;
    logic [IW-1:0] sparse_waddr;
    logic [IW-1:0] sparse_wdata;

    // Slot of the last live id; valid whenever a free reaches the swap.
    assign last_slot = IW'(count_reg - CW'(1));

    // Read addresses: an allocate looks at the first free slot, a free at
    // the last live slot and at the slot of the id being freed.
    assign dense_raddr  = (req_type == REQ_FREE) ? last_slot : IW'(count_reg);
    assign sparse_raddr = IW'(free_id);

    // Write port steering for the reset sweep and the two swap steps.
    always_comb
    begin
        dense_we     = 1'b0;
        dense_waddr  = init_idx_reg;
        dense_wdata  = init_idx_reg;
        sparse_we    = 1'b0;
        sparse_waddr = init_idx_reg;
        sparse_wdata = init_idx_reg;
        priority if (cmd.init_write)
        begin
            dense_we  = 1'b1;
            sparse_we = 1'b1;
        end
        else if (cmd.swap_a)
        begin
            dense_we     = 1'b1;
            dense_waddr  = sparse_rd_reg;
            dense_wdata  = dense_rd_reg;
            sparse_we    = 1'b1;
            sparse_waddr = id_reg;
            sparse_wdata = last_slot;
        end
        else if (cmd.swap_b)
        begin
            dense_we     = 1'b1;
            dense_waddr  = last_slot;
            dense_wdata  = id_reg;
            sparse_we    = 1'b1;
            sparse_waddr = dense_rd_reg;
            sparse_wdata = sparse_rd_reg;
        end
    end

    // Table memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (dense_we)
        begin
            dense_mem[dense_waddr] <= dense_wdata;
        end
        if (sparse_we)
        begin
            sparse_mem[sparse_waddr] <= sparse_wdata;
        end
        if (cmd.capture)
        begin
            dense_rd_reg  <= dense_mem[dense_raddr];
            sparse_rd_reg <= sparse_mem[sparse_raddr];
        end
    end

    // Captured request payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_free_reg <= req_type;
            id_ok_reg    <= (32'(free_id) < ID_CAPACITY);
            id_reg       <= IW'(free_id);
        end
    end

    // Live count update.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Control registers: sweep index, live count and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_idx_reg <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.init_write)
            begin
                init_idx_reg <= init_idx_reg + IW'(1);
            end
            count_reg <= count_next;
            done_reg  <= cmd.emit;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg     <= cmd.status;
            alloc_id_reg   <= cmd.give_id ? ID_FIELD_W'(dense_rd_reg) : '0;
            live_count_reg <= COUNT_FIELD_W'(count_next);
        end
    end

    assign stat.init_last = (init_idx_reg == IW'(ID_CAPACITY - 1));
    assign stat.req_free  = req_free_reg;
    assign stat.full      = (count_reg == CW'(ID_CAPACITY));
    assign stat.live_ok   = id_ok_reg && (CW'(sparse_rd_reg) < count_reg);

    assign done       = done_reg;
    assign status     = status_reg;
    assign alloc_id   = alloc_id_reg;
    assign live_count = live_count_reg;

endmodule

FILE: bench/sparse_set_id_allocator_top_tb.sv
`timescale 1ns / 1ps

module sparse_set_id_allocator_top_tb;
    import ssa_pkg::*;

    localparam int ID_CAP         = ID_CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 600;
    localparam int RANDOM_ITEMS   = 400;

    // One expected response of the allocator.
    typedef struct {
        status_t                  status;
        logic [ID_FIELD_W-1:0]    alloc_id;
        logic [COUNT_FIELD_W-1:0] live_count;
    } alloc_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     req_type = REQ_ALLOC;
    logic [ID_FIELD_W-1:0]    free_id = '0;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic [ID_FIELD_W-1:0]    alloc_id;
    logic [COUNT_FIELD_W-1:0] live_count;

    // Shadow copy of the sparse set, updated as each transaction is accepted.
    logic [ID_FIELD_W-1:0] dense_ids [ID_CAP];
    logic [ID_FIELD_W-1:0] slot_of_id [ID_CAP];
    int                    live_ids;

    alloc_result_t pending_results [$];
    int            error_count = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;

    sparse_set_id_allocator_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .free_id    (free_id),
        .done       (done),
        .status     (status),
        .alloc_id   (alloc_id),
        .live_count (live_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the shadow tables and returns the response it must produce.
    function automatic alloc_result_t apply_request(input logic req,
                                                    input logic [ID_FIELD_W-1:0] id);
        alloc_result_t         res;
        int                    slot;
        int                    last_slot;
        logic [ID_FIELD_W-1:0] last_id;
        res.status   = STATUS_OK;
        res.alloc_id = '0;
        if (req == REQ_ALLOC)
        begin
            if (live_ids >= ID_CAP)
                res.status = STATUS_FULL;
            else
            begin
                res.alloc_id = dense_ids[live_ids];
                live_ids++;
            end
        end
        else
        begin
            slot = slot_of_id[id];
            if (slot >= live_ids)
                res.status = STATUS_NOT_LIVE;
            else
            begin
                // Swap the freed id with the last live id in both tables.
                last_slot             = live_ids - 1;
                last_id               = dense_ids[last_slot];
                dense_ids[slot]       = last_id;
                dense_ids[last_slot]  = id;
                slot_of_id[last_id]   = slot[ID_FIELD_W-1:0];
                slot_of_id[id]        = last_slot[ID_FIELD_W-1:0];
                live_ids              = last_slot;
            end
        end
        res.live_count = live_ids[COUNT_FIELD_W-1:0];
        return res;
    endfunction

    // Issues one request, inserting a random gap between bursts, and waits for acceptance.
    task automatic send_request(input logic req, input logic [ID_FIELD_W-1:0] id);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        start    <= 1'b1;
        req_type <= req;
        free_id  <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_request(req, id));
        burst_left--;
    endtask

    // Frees on an empty set, the lowest and highest ids, and allocation order.
    task automatic test_empty_and_extremes();
        send_request(REQ_FREE, 6'd0);
        send_request(REQ_FREE, 6'd63);
        send_request(REQ_ALLOC, 6'd63);
        send_request(REQ_ALLOC, 6'd0);
        send_request(REQ_ALLOC, 6'd42);
        send_request(REQ_FREE, 6'd63);
        send_request(REQ_FREE, 6'd0);
        send_request(REQ_FREE, 6'd0);
    endtask

    // Frees from the middle, the front and the back of the live part, then reuse.
    task automatic test_swap_and_reuse();
        send_request(REQ_ALLOC, 6'd21);
        send_request(REQ_ALLOC, 6'd0);
        send_request(REQ_FREE, 6'd2);
        send_request(REQ_FREE, 6'd2);
        send_request(REQ_ALLOC, 6'd63);
        send_request(REQ_FREE, 6'd1);
        send_request(REQ_FREE, 6'd3);
        send_request(REQ_FREE, 6'd2);
        send_request(REQ_FREE, 6'd2);
        send_request(REQ_ALLOC, 6'd0);
        send_request(REQ_FREE, 6'd63);
    endtask

    // Random traffic that alternately fills the set to capacity and drains it to empty.
    task automatic test_random_fill_drain();
        logic                  filling;
        logic                  req;
        logic [ID_FIELD_W-1:0] id;
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (live_ids == ID_CAP)
                filling = 1'b0;
            else if (live_ids == 0)
                filling = 1'b1;
            if (filling)
                req = ($urandom_range(0, 99) < 85) ? REQ_ALLOC : REQ_FREE;
            else
                req = ($urandom_range(0, 99) < 85) ? REQ_FREE : REQ_ALLOC;
            id = ID_FIELD_W'($urandom_range(0, ID_CAP - 1));
            // Most frees name a live id; the rest are random and often not live.
            if (req == REQ_FREE && live_ids > 0 && $urandom_range(0, 99) < 85)
                id = dense_ids[$urandom_range(0, live_ids - 1)];
            send_request(req, id);
        end
    endtask

    // Compares each strobed response with the oldest expectation.
    always @(posedge clk)
    begin
        alloc_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response with no request outstanding: status %0d alloc_id %0d live_count %0d",
                       status, alloc_id, live_count);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, status);
                    error_count++;
                end
                if (alloc_id !== exp_res.alloc_id)
                begin
                    $error("alloc_id: expected %0d, actual %0d", exp_res.alloc_id, alloc_id);
                    error_count++;
                end
                if (live_count !== exp_res.live_count)
                begin
                    $error("live_count: expected %0d, actual %0d", exp_res.live_count, live_count);
                    error_count++;
                end
            end
        end
    end

    // Cycles since the last transaction in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("sparse_set_id_allocator_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < ID_CAP; i++)
        begin
            dense_ids[i]  = i[ID_FIELD_W-1:0];
            slot_of_id[i] = i[ID_FIELD_W-1:0];
        end
        live_ids = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_swap_and_reuse();
        test_random_fill_drain();

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("sparse_set_id_allocator_top_tb OK");
        else
            $display("sparse_set_id_allocator_top_tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ssa_pkg.sv
hdl/ssa_ctrl.sv
hdl/ssa_datapath.sv
hdl/sparse_set_id_allocator_top.sv
bench/sparse_set_id_allocator_top_tb.sv
